>>> sv/gpbk_pkg.sv
package gpbk_pkg;

    // Number of pins that take part in interrupt logic
    localparam int PIN_COUNT = 32;
    localparam logic [31:0] PIN_MASK = 32'hFFFF_FFFF >> (32 - PIN_COUNT);

    localparam logic [31:0] LOW_HALF  = 32'h0000_FFFF;
    localparam logic [31:0] HIGH_HALF = 32'hFFFF_0000;

    // Opcodes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_EVENT = 2'd2;

    // Access sizes
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;

    // Register word index (byte offset / 4)
    localparam logic [2:0] REG_DATA_OUT   = 3'd0;
    localparam logic [2:0] REG_DIRECTION  = 3'd1;
    localparam logic [2:0] REG_PAD_STATUS = 3'd2;
    localparam logic [2:0] REG_SENSE_LOW  = 3'd3;
    localparam logic [2:0] REG_SENSE_HIGH = 3'd4;
    localparam logic [2:0] REG_IRQ_MASK   = 3'd5;
    localparam logic [2:0] REG_IRQ_STATUS = 3'd6;
    localparam logic [2:0] REG_EDGE_SEL   = 3'd7;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [4:0]  byte_offset;
        logic [1:0]  access_size;
        logic [31:0] write_data;
        logic [31:0] pad_level;
        logic [31:0] pending_edges;
    } t_req;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_low;
        logic        irq_high;
        logic        access_error;
    } t_rsp;

endpackage

>>> sv/gpbk_req_if.sv
interface gpbk_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [4:0]  byte_offset;
    logic [1:0]  access_size;
    logic [31:0] write_data;
    logic [31:0] pad_level;
    logic [31:0] pending_edges;

    modport source (
        output valid, opcode, byte_offset, access_size, write_data, pad_level,
               pending_edges,
        input  ready
    );
    modport sink (
        input  valid, opcode, byte_offset, access_size, write_data, pad_level,
               pending_edges,
        output ready
    );
endinterface

>>> sv/gpbk_rsp_if.sv
interface gpbk_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        irq_low;
    logic        irq_high;
    logic        access_error;

    modport source (
        output valid, read_data, irq_low, irq_high, access_error,
        input  ready
    );
    modport sink (
        input  valid, read_data, irq_low, irq_high, access_error,
        output ready
    );
endinterface

>>> sv/gpbk_in_stage.sv
// Input register: holds one request for the update logic.
module gpbk_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    gpbk_req_if.sink          i_req,
    input  logic              i_take,
    output logic              o_valid,
    output gpbk_pkg::t_req    o_req
);

    logic           r_valid;
    gpbk_pkg::t_req r_req;

    assign i_req.ready = !r_valid || i_take;
    assign o_valid     = r_valid;
    assign o_req       = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_req.opcode        <= i_req.opcode;
            r_req.byte_offset   <= i_req.byte_offset;
            r_req.access_size   <= i_req.access_size;
            r_req.write_data    <= i_req.write_data;
            r_req.pad_level     <= i_req.pad_level;
            r_req.pending_edges <= i_req.pending_edges;
        end
    end

endmodule

>>> sv/gpbk_core.sv
// Register file and single-pass update of one request.
module gpbk_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  gpbk_pkg::t_req    i_req,
    output gpbk_pkg::t_rsp    o_rsp
);

    typedef struct packed {
        logic [31:0] data_out;
        logic [31:0] direction;
        logic [31:0] sense_low_pins;
        logic [31:0] sense_high_pins;
        logic [31:0] irq_mask;
        logic [31:0] irq_status;
        logic [31:0] both_edge_select;
    } t_regs;

    t_regs       r_regs;
    t_regs       n_regs;
    t_regs       regs_rd;
    logic [2:0]  idx;
    logic        word_acc;
    logic        misal;
    logic [4:0]  shift;
    logic [4:0]  shift_h;
    logic [31:0] lane;
    logic [31:0] old_word;
    logic [31:0] merged;

    function automatic logic [31:0] f_pad(input t_regs r, input logic [31:0] pads);
        return (r.data_out & r.direction) | (pads & ~r.direction);
    endfunction

    // Level-mode pins follow the level condition; edge bits OR in.
    function automatic logic [31:0] f_refresh(input t_regs r, input logic [31:0] pads,
                                              input logic [31:0] edges);
        logic [31:0] level;
        logic [31:0] lmask;
        logic [31:0] active;
        logic [1:0]  sense;
        level  = f_pad(r, pads);
        lmask  = '0;
        active = '0;
        for (int p = 0; p < 32; p++) begin
            sense = (p < 16) ? r.sense_low_pins[(p % 16) * 2 +: 2]
                             : r.sense_high_pins[(p % 16) * 2 +: 2];
            if (p < gpbk_pkg::PIN_COUNT && !r.both_edge_select[p] && !sense[1]) begin
                lmask[p]  = 1'b1;
                active[p] = sense[0] ? level[p] : !level[p];
            end
        end
        return (r.irq_status & ~lmask) | active | (edges & gpbk_pkg::PIN_MASK);
    endfunction

    function automatic logic [31:0] f_read(input t_regs r, input logic [31:0] pads,
                                           input logic [2:0] sel);
        logic [31:0] v;
        case (sel)
            gpbk_pkg::REG_DATA_OUT:   v = r.data_out;
            gpbk_pkg::REG_DIRECTION:  v = r.direction;
            gpbk_pkg::REG_PAD_STATUS: v = f_pad(r, pads);
            gpbk_pkg::REG_SENSE_LOW:  v = r.sense_low_pins;
            gpbk_pkg::REG_SENSE_HIGH: v = r.sense_high_pins;
            gpbk_pkg::REG_IRQ_MASK:   v = r.irq_mask;
            gpbk_pkg::REG_IRQ_STATUS: v = r.irq_status;
            default:                  v = r.both_edge_select;
        endcase
        return v;
    endfunction

    assign idx      = i_req.byte_offset[4:2];
    assign word_acc = i_req.access_size[1];        // size 3 acts as word
    assign misal    = |i_req.byte_offset[1:0];
    assign shift    = {i_req.byte_offset[1:0], 3'b000};
    assign shift_h  = {i_req.byte_offset[1], 4'b0000};
    assign lane     = ((i_req.access_size == gpbk_pkg::SZ_BYTE) ? 32'h0000_00FF
                                                                : 32'h0000_FFFF) << shift;

    always_comb begin
        regs_rd = r_regs;
        if (idx == gpbk_pkg::REG_IRQ_STATUS) begin
            regs_rd.irq_status = f_refresh(r_regs, i_req.pad_level, i_req.pending_edges);
        end
        old_word = f_read(regs_rd, i_req.pad_level, idx);
        merged   = word_acc ? i_req.write_data
                            : ((old_word & ~lane) | ((i_req.write_data << shift) & lane));
        n_regs   = r_regs;
        o_rsp    = '0;

        case (i_req.opcode)
            gpbk_pkg::OP_READ: begin
                if (word_acc && misal) begin
                    o_rsp.access_error = 1'b1;
                end else begin
                    n_regs = regs_rd;
                    if (word_acc) begin
                        o_rsp.read_data = old_word;
                    end else if (i_req.access_size == gpbk_pkg::SZ_BYTE) begin
                        o_rsp.read_data = (old_word >> shift) & 32'h0000_00FF;
                    end else begin
                        o_rsp.read_data = (old_word >> shift_h) & 32'h0000_FFFF;
                    end
                end
            end
            gpbk_pkg::OP_WRITE: begin
                if (word_acc && misal) begin
                    o_rsp.access_error = 1'b1;
                end else begin
                    // sub-word write carries the side effects of its read
                    if (!word_acc) begin
                        n_regs = regs_rd;
                    end
                    case (idx)
                        gpbk_pkg::REG_DATA_OUT:   n_regs.data_out = merged;
                        gpbk_pkg::REG_DIRECTION:  n_regs.direction = merged;
                        gpbk_pkg::REG_PAD_STATUS: ;
                        gpbk_pkg::REG_SENSE_LOW:  n_regs.sense_low_pins = merged;
                        gpbk_pkg::REG_SENSE_HIGH: n_regs.sense_high_pins = merged;
                        gpbk_pkg::REG_IRQ_MASK:   n_regs.irq_mask = merged;
                        gpbk_pkg::REG_IRQ_STATUS: n_regs.irq_status = n_regs.irq_status & ~merged;
                        default:                  n_regs.both_edge_select = merged;
                    endcase
                    if (idx != gpbk_pkg::REG_PAD_STATUS) begin
                        n_regs.irq_status = f_refresh(n_regs, i_req.pad_level,
                                                      i_req.pending_edges);
                    end
                end
            end
            gpbk_pkg::OP_EVENT: begin
                n_regs.irq_status = f_refresh(r_regs, i_req.pad_level, i_req.pending_edges);
            end
            default: ;
        endcase

        o_rsp.irq_low  = |(n_regs.irq_status & n_regs.irq_mask & gpbk_pkg::LOW_HALF);
        o_rsp.irq_high = |(n_regs.irq_status & n_regs.irq_mask & gpbk_pkg::HIGH_HALF);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= '0;
        end else if (i_fire) begin
            r_regs <= n_regs;
        end
    end

    // rejected access leaves every register alone
    a_err_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_rsp.access_error |=> r_regs == $past(r_regs))
        else $error("state changed on access error");

    a_err_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.access_error |-> o_rsp.read_data == '0)
        else $error("read data on access error");

    a_plain_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_req.opcode == gpbk_pkg::OP_READ && idx != gpbk_pkg::REG_IRQ_STATUS
        |=> r_regs == $past(r_regs))
        else $error("read of plain register changed state");

    a_irq_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire |=> (|(r_regs.irq_status & r_regs.irq_mask & gpbk_pkg::LOW_HALF))
                   == $past(o_rsp.irq_low))
        else $error("irq_low does not match committed state");

endmodule

>>> sv/gpbk_out_stage.sv
// Result register toward the response channel.
module gpbk_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  gpbk_pkg::t_rsp    i_rsp,
    output logic              o_take,
    gpbk_rsp_if.source        o_rsp
);

    logic           r_valid;
    gpbk_pkg::t_rsp r_rsp;

    assign o_take             = !r_valid || o_rsp.ready;
    assign o_rsp.valid        = r_valid;
    assign o_rsp.read_data    = r_rsp.read_data;
    assign o_rsp.irq_low      = r_rsp.irq_low;
    assign o_rsp.irq_high     = r_rsp.irq_high;
    assign o_rsp.access_error = r_rsp.access_error;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_rsp <= i_rsp;
        end
    end

endmodule

>>> sv/gpio_bank_with_level_interrupts.sv
// 32-pin GPIO bank with level-sensitive interrupt status. Each request is a
// bus read, a byte/half/word bus write, or a pad-change event, and carries
// the sampled pad levels and any externally detected edge bits. Registers by
// byte offset: 0x00 data out, 0x04 direction (1 = output), 0x08 pad status
// (read only), 0x0C/0x10 two-bit sense codes for pins 0-15/16-31 (0 active
// low, 1 active high, others no level mode), 0x14 mask, 0x18 status (write
// one to clear), 0x1C both-edge select (excludes a pin from level mode).
// Status is recomputed on a status read, on every write except to pad
// status, and on each pad event. Sub-word writes read-merge-write the whole
// word, status included. A misaligned word access returns access_error and
// changes nothing. Every request gives exactly one response; irq_low and
// irq_high report pending unmasked status after that request. Throughput is
// one request per clock while the response side is ready. The request sits
// in an input register, the whole register update is done in one pass, and
// the result register captures it when that register is free to take it.
// While a finished response waits downstream, the input register can still
// take one more request before the input stalls.
module gpio_bank_with_level_interrupts (
    input  logic         i_clk,
    input  logic         i_rst_n,
    gpbk_req_if.sink     i_req,
    gpbk_rsp_if.source   o_rsp
);

    logic           s1_valid;
    gpbk_pkg::t_req s1_req;
    gpbk_pkg::t_rsp s1_rsp;
    logic           take;
    logic           fire;

    // request moves from input register into state and result register
    assign fire = s1_valid && take;

    gpbk_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_take  (take),
        .o_valid (s1_valid),
        .o_req   (s1_req)
    );

    gpbk_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_req   (s1_req),
        .o_rsp   (s1_rsp)
    );

    gpbk_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .i_rsp   (s1_rsp),
        .o_take  (take),
        .o_rsp   (o_rsp)
    );

endmodule
